### hw/rtl/mixed_radix_index_converter_macros.svh
// Assertion macros for the mixed-radix index converter.
`ifndef MIXED_RADIX_INDEX_CONVERTER_MACROS_SVH
`define MIXED_RADIX_INDEX_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define MRC_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define MRC_ASSERT_NEXT(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define MRC_ASSERT_IMP(lbl, clk, rst, a, b)
`define MRC_ASSERT_NEXT(lbl, clk, a, b)
`endif

`endif

### hw/rtl/mrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared constants, codes and the pipeline stage record of the converter.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int COORD_BITS = 8;
  localparam int INDEX_BITS = 32;
  localparam int TOTAL_BITS = 33;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int DIMS_BITS  = 3;
  localparam int NUM_STAGES = MAX_DIMS * COORD_BITS + 1;
  localparam int ADDR_BITS  = 5;

  typedef enum logic {
    ACT_TO_INDEX = 1'b0,
    ACT_TO_COORD = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    REG_DIMS_IN_USE = 3'd0,
    REG_DIM_SIZE_0  = 3'd1,
    REG_DIM_SIZE_1  = 3'd2,
    REG_DIM_SIZE_2  = 3'd3,
    REG_DIM_SIZE_3  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    action_t                                  act;
    logic                                     oor;
    logic [INDEX_BITS-1:0]                    rem;
    logic [INDEX_BITS-1:0]                    idx;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0]      coord;
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0]      prod;
  } stage_t;

endpackage

### hw/rtl/mrc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_req_if
// Request channel: action, coordinates and linear index.
// ----------------------------------------------------------------------------
interface mrc_req_if
  import mrc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] in_coord_0;
  logic [COORD_BITS-1:0] in_coord_1;
  logic [COORD_BITS-1:0] in_coord_2;
  logic [COORD_BITS-1:0] in_coord_3;
  logic [INDEX_BITS-1:0] in_index;

  modport source (output valid, action, in_coord_0, in_coord_1, in_coord_2, in_coord_3,
                  in_index, input ready);
  modport sink   (input valid, action, in_coord_0, in_coord_1, in_coord_2, in_coord_3,
                  in_index, output ready);
endinterface

### hw/rtl/mrc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_rsp_if
// Result channel: linear index, coordinates and out-of-range flag.
// ----------------------------------------------------------------------------
interface mrc_rsp_if
  import mrc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] out_index;
  logic [COORD_BITS-1:0] out_coord_0;
  logic [COORD_BITS-1:0] out_coord_1;
  logic [COORD_BITS-1:0] out_coord_2;
  logic [COORD_BITS-1:0] out_coord_3;
  logic                  out_of_range;

  modport source (output valid, out_index, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, out_of_range, input ready);
  modport sink   (input valid, out_index, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, out_of_range, output ready);
endinterface

### hw/rtl/mixed_radix_index_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_index_converter
// Row-major coordinate/index converter for arrays of up to four dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: action 0 folds in_coord_* into a linear index,
//   action 1 splits in_index into coordinates. rsp returns exactly one item
//   for each request, in order. Both use valid/ready.
//   The APB port sets the dimension count and the extents; write it only
//   while no item is in flight. req.ready drops in the access cycle and
//   stays low while the strides and the cell count settle.
//   Pipeline: 33 register stages. A new item is taken every cycle while rsp
//   accepts results and no configuration write is settling.
//   Index-to-coordinate work is a restoring division against the stride of
//   each dimension, one quotient bit per stage: eight stages per dimension
//   set the depth. Coordinate-to-index uses one multiply stage and one sum.
//   When rsp stalls, each full stage holds while the one after it also holds; empty
//   stages keep filling, so nothing is lost or repeated.
//   Reset (rst, synchronous) empties the pipeline and restores one
//   dimension of extent one.
// ----------------------------------------------------------------------------
`include "mixed_radix_index_converter_macros.svh"

module mixed_radix_index_converter
  import mrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  mrc_req_if.sink              req,
  mrc_rsp_if.source            rsp
);

  localparam int LAST = NUM_STAGES - 1;

  logic [DIMS_BITS-1:0]  dims_in_use;
  logic [SIZE_BITS-1:0]  dim_size [MAX_DIMS];
  logic [DIMS_BITS-1:0]  ndims;
  logic [MAX_DIMS-1:0]   used;
  logic [SIZE_BITS-1:0]  es [MAX_DIMS];
  logic [TOTAL_BITS-1:0] stride [MAX_DIMS];
  logic [TOTAL_BITS-1:0] total_cells;
  logic [2:0]            wr_idx;
  logic                  cfg_wr;
  logic [2:0]            cfg_hold;
  logic                  in_open;
  logic                  rsp_zero;

  stage_t               st [NUM_STAGES];
  stage_t               nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES:0]   rdy;

  // Configuration port
  assign pready = 1'b1;
  assign wr_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIMS_BITS'(1);
      for (int i = 0; i < MAX_DIMS; i++) dim_size[i] <= SIZE_BITS'(1);
    end else if (cfg_wr) begin
      unique case (wr_idx)
        REG_DIMS_IN_USE: dims_in_use <= pwdata[DIMS_BITS-1:0];
        REG_DIM_SIZE_0:  dim_size[0] <= pwdata[SIZE_BITS-1:0];
        REG_DIM_SIZE_1:  dim_size[1] <= pwdata[SIZE_BITS-1:0];
        REG_DIM_SIZE_2:  dim_size[2] <= pwdata[SIZE_BITS-1:0];
        REG_DIM_SIZE_3:  dim_size[3] <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_DIMS_IN_USE: prdata = 32'(dims_in_use);
      REG_DIM_SIZE_0:  prdata = 32'(dim_size[0]);
      REG_DIM_SIZE_1:  prdata = 32'(dim_size[1]);
      REG_DIM_SIZE_2:  prdata = 32'(dim_size[2]);
      REG_DIM_SIZE_3:  prdata = 32'(dim_size[3]);
      default:         prdata = '0;
    endcase
  end

  // Hold off new items while strides and cell count settle after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= '0;
    end else if (cfg_wr) begin
      cfg_hold <= 3'd4;
    end else if (cfg_hold != '0) begin
      cfg_hold <= cfg_hold - 3'd1;
    end
  end

  assign in_open = !cfg_wr && (cfg_hold == '0);

  // Clamp the dimension count and extents; unused dimensions get extent one
  always_comb begin
    if (dims_in_use == '0) ndims = DIMS_BITS'(1);
    else if (dims_in_use > DIMS_BITS'(MAX_DIMS)) ndims = DIMS_BITS'(MAX_DIMS);
    else ndims = dims_in_use;
    for (int i = 0; i < MAX_DIMS; i++) begin
      used[i] = (DIMS_BITS'(i) < ndims);
      if (!used[i] || dim_size[i] == '0) es[i] = SIZE_BITS'(1);
      else if (dim_size[i] > SIZE_BITS'(1 << COORD_BITS)) es[i] = SIZE_BITS'(1 << COORD_BITS);
      else es[i] = dim_size[i];
    end
  end

  // Strides: one multiply per register, each built from the registered stride after it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIMS; i++) stride[i] <= TOTAL_BITS'(1);
      total_cells <= TOTAL_BITS'(1);
    end else begin
      stride[MAX_DIMS-1] <= TOTAL_BITS'(1);
      for (int i = 0; i < MAX_DIMS - 1; i++)
        stride[i] <= TOTAL_BITS'(stride[i+1] * es[i+1]);
      total_cells <= TOTAL_BITS'(stride[0] * es[0]);
    end
  end

  // Stage 0: capture the item and check bounds
  always_comb begin
    nxt[0]     = '0;
    nxt[0].act = action_t'(req.action);
    nxt[0].rem = req.in_index;
    if (req.action == ACT_TO_INDEX) begin
      nxt[0].coord[0] = req.in_coord_0;
      nxt[0].coord[1] = req.in_coord_1;
      nxt[0].coord[2] = req.in_coord_2;
      nxt[0].coord[3] = req.in_coord_3;
      for (int i = 0; i < MAX_DIMS; i++)
        if (used[i] && SIZE_BITS'(nxt[0].coord[i]) >= es[i]) nxt[0].oor = 1'b1;
      for (int i = 0; i < MAX_DIMS; i++)
        if (!used[i]) nxt[0].coord[i] = '0;
    end else begin
      nxt[0].oor = (TOTAL_BITS'(req.in_index) >= total_cells);
    end
  end

  // Each stage advances while the one after it can take its item
  assign rdy[NUM_STAGES] = rsp.ready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign req.ready = rdy[0] && in_open;

  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    localparam int D = (k - 1) / COORD_BITS;
    localparam int B = COORD_BITS - 1 - ((k - 1) % COORD_BITS);
    logic [INDEX_BITS+COORD_BITS:0] trial;

    always_comb begin
      nxt[k] = st[k-1];
      trial  = (INDEX_BITS + COORD_BITS + 1)'(stride[D]) << B;
      if (st[k-1].act == ACT_TO_INDEX) begin
        if (k == 1) begin
          for (int i = 0; i < MAX_DIMS; i++)
            nxt[k].prod[i] = INDEX_BITS'(st[k-1].coord[i] * stride[i]);
        end
        if (k == 2) begin
          nxt[k].idx = st[k-1].prod[0] + st[k-1].prod[1] + st[k-1].prod[2]
                     + st[k-1].prod[3];
        end
      end else if ((INDEX_BITS + COORD_BITS + 1)'(st[k-1].rem) >= trial) begin
        // take one quotient bit of this dimension's coordinate
        nxt[k].rem        = st[k-1].rem - INDEX_BITS'(trial);
        nxt[k].coord[D][B] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? (req.valid && in_open) : v[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[k]) st[k] <= nxt[k];
    end
  end

  // Output from the last stage
  assign rsp.valid        = v[LAST];
  assign rsp.out_of_range = st[LAST].oor;
  assign rsp.out_index    = (st[LAST].act == ACT_TO_INDEX && !st[LAST].oor)
                            ? st[LAST].idx : '0;
  assign rsp.out_coord_0  = (st[LAST].act == ACT_TO_COORD && !st[LAST].oor)
                            ? st[LAST].coord[0] : '0;
  assign rsp.out_coord_1  = (st[LAST].act == ACT_TO_COORD && !st[LAST].oor)
                            ? st[LAST].coord[1] : '0;
  assign rsp.out_coord_2  = (st[LAST].act == ACT_TO_COORD && !st[LAST].oor)
                            ? st[LAST].coord[2] : '0;
  assign rsp.out_coord_3  = (st[LAST].act == ACT_TO_COORD && !st[LAST].oor)
                            ? st[LAST].coord[3] : '0;

  assign rsp_zero = rsp.out_index == '0 && rsp.out_coord_0 == '0
                    && rsp.out_coord_1 == '0 && rsp.out_coord_2 == '0
                    && rsp.out_coord_3 == '0;

  `MRC_ASSERT_NEXT(a_reset_empty, clk, rst, !rsp.valid)
  `MRC_ASSERT_IMP(a_total_nonzero, clk, rst, 1'b1, total_cells != '0)
  `MRC_ASSERT_IMP(a_oor_zero, clk, rst, rsp.valid && rsp.out_of_range, rsp_zero)
  `MRC_ASSERT_IMP(a_accept_fills, clk, rst, req.valid && req.ready, ##1 v[0])

endmodule
